>>> hw/rtl/snx3_pkg.sv
`default_nettype none
package snx3_pkg;

  // lattice offsets are in units of 1/(6*65536)
  typedef logic signed [23:0] ofs_t;

  typedef struct packed {
    ofs_t       dx;
    ofs_t       dy;
    ofs_t       dz;
    logic [7:0] ci;
    logic [7:0] cj;
    logic [7:0] ck;
  } corner_t;

  localparam int unsigned NumStages = 14;

  localparam logic [23:0] UnitOne   = 24'd393216;
  localparam logic [23:0] SixthOne  = 24'd65536;
  localparam logic [38:0] FallTop   = 39'd463856467968;  // 108 * 2^32
  localparam logic [25:0] Div45Mul  = 26'd47721859;       // ceil(2^31 / 45)
  localparam logic [21:0] Div3Mul   = 22'd1398102;        // ceil(2^22 / 3)
  localparam logic [20:0] Div3Bias1 = 21'd393216;         // 3 * 2^17
  localparam logic [20:0] Div3Bias2 = 21'd786432;         // 3 * 2^18

  localparam logic [7:0] Perm [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
    8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
    8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
    8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
    8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
    8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
    8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
    8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
    8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
    8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  // floor(n / 3), exact for n < 2^21
  function automatic logic [20:0] div3(input logic [20:0] n);
    logic [42:0] prod;
    prod = 43'(n) * 43'(Div3Mul);
    return prod[42:22];
  endfunction

  // floor(n / 45), exact for n < 2^25
  function automatic logic [24:0] div45(input logic [24:0] n);
    logic [50:0] prod;
    prod = 51'(n) * 51'(Div45Mul);
    return prod[50:26] >> 5;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/snx3_lattice.sv
`default_nettype none
module snx3_lattice import snx3_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  output logic signed [23:0]      x0_o,
  output logic signed [23:0]      y0_o,
  output logic signed [23:0]      z0_o,
  output logic [7:0]              ci_o,
  output logic [7:0]              cj_o,
  output logic [7:0]              ck_o
);

  logic signed [34:0] xw, yw, zw, sx, sy, sz;
  logic signed [18:0] sx_d, sy_d, sz_d, sx_q, sy_q, sz_q;
  logic [31:0]        x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic [20:0]        qx, qy, qz;
  logic [7:0]         i_q, j_q, k_q, ijk, i6, j6, k6;
  logic [23:0]        x6, y6, z6;
  logic [23:0]        x0_d, y0_d, z0_d;
  logic [23:0]        x0_q, y0_q, z0_q;
  logic [7:0]         ci_q, cj_q, ck_q;

  // skew: (4x + y + z) / 3 in cell units, floor by 2^16 first
  always_comb begin
    xw = 35'(x_i);
    yw = 35'(y_i);
    zw = 35'(z_i);
    sx = (xw <<< 2) + yw + zw;
    sy = xw + (yw <<< 2) + zw;
    sz = xw + yw + (zw <<< 2);
    sx_d = sx[34:16];
    sy_d = sy[34:16];
    sz_d = sz[34:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sz_q <= sz_d;
      x1_q <= x_i;
      y1_q <= y_i;
      z1_q <= z_i;
    end
  end

  // true floor by 3, biased positive; only the low cell bits are kept
  always_comb begin
    qx = div3(21'(sx_q) + Div3Bias1);
    qy = div3(21'(sy_q) + Div3Bias1);
    qz = div3(21'(sz_q) + Div3Bias1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i_q  <= qx[7:0];
      j_q  <= qy[7:0];
      k_q  <= qz[7:0];
      x2_q <= x1_q;
      y2_q <= y1_q;
      z2_q <= z1_q;
    end
  end

  // unskew, exact modulo 2^24
  always_comb begin
    ijk  = i_q + j_q + k_q;
    i6   = {i_q[6:0], 1'b0} + {i_q[5:0], 2'b00};
    j6   = {j_q[6:0], 1'b0} + {j_q[5:0], 2'b00};
    k6   = {k_q[6:0], 1'b0} + {k_q[5:0], 2'b00};
    x6   = {x2_q[22:0], 1'b0} + {x2_q[21:0], 2'b00};
    y6   = {y2_q[22:0], 1'b0} + {y2_q[21:0], 2'b00};
    z6   = {z2_q[22:0], 1'b0} + {z2_q[21:0], 2'b00};
    x0_d = x6 - {i6, 16'h0000} + {ijk, 16'h0000};
    y0_d = y6 - {j6, 16'h0000} + {ijk, 16'h0000};
    z0_d = z6 - {k6, 16'h0000} + {ijk, 16'h0000};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      z0_q <= z0_d;
      ci_q <= i_q;
      cj_q <= j_q;
      ck_q <= k_q;
    end
  end

  assign x0_o = x0_q;
  assign y0_o = y0_q;
  assign z0_o = z0_q;
  assign ci_o = ci_q;
  assign cj_o = cj_q;
  assign ck_o = ck_q;

endmodule
`default_nettype wire

>>> hw/rtl/snx3_simplex.sv
`default_nettype none
module snx3_simplex import snx3_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [23:0] x0_i,
  input  wire logic signed [23:0] y0_i,
  input  wire logic signed [23:0] z0_i,
  input  wire logic [7:0]         ci_i,
  input  wire logic [7:0]         cj_i,
  input  wire logic [7:0]         ck_i,
  output corner_t [3:0]           corner_o
);

  logic          i1, j1, k1, i2, j2, k2;
  corner_t [3:0] corner_d, corner_q;

  // rank offsets; ties go x before y before z
  always_comb begin
    i1 = 1'b0; j1 = 1'b0; k1 = 1'b0;
    i2 = 1'b0; j2 = 1'b0; k2 = 1'b0;
    if (x0_i >= y0_i) begin
      if (y0_i >= z0_i) begin
        i1 = 1'b1; i2 = 1'b1; j2 = 1'b1;
      end else if (x0_i >= z0_i) begin
        i1 = 1'b1; i2 = 1'b1; k2 = 1'b1;
      end else begin
        k1 = 1'b1; i2 = 1'b1; k2 = 1'b1;
      end
    end else begin
      if (y0_i < z0_i) begin
        k1 = 1'b1; j2 = 1'b1; k2 = 1'b1;
      end else if (x0_i < z0_i) begin
        j1 = 1'b1; j2 = 1'b1; k2 = 1'b1;
      end else begin
        j1 = 1'b1; i2 = 1'b1; j2 = 1'b1;
      end
    end

    corner_d[0].dx = x0_i;
    corner_d[0].dy = y0_i;
    corner_d[0].dz = z0_i;
    corner_d[0].ci = ci_i;
    corner_d[0].cj = cj_i;
    corner_d[0].ck = ck_i;

    corner_d[1].dx = x0_i - (i1 ? UnitOne : 24'd0) + SixthOne;
    corner_d[1].dy = y0_i - (j1 ? UnitOne : 24'd0) + SixthOne;
    corner_d[1].dz = z0_i - (k1 ? UnitOne : 24'd0) + SixthOne;
    corner_d[1].ci = ci_i + 8'(i1);
    corner_d[1].cj = cj_i + 8'(j1);
    corner_d[1].ck = ck_i + 8'(k1);

    corner_d[2].dx = x0_i - (i2 ? UnitOne : 24'd0) + {SixthOne[22:0], 1'b0};
    corner_d[2].dy = y0_i - (j2 ? UnitOne : 24'd0) + {SixthOne[22:0], 1'b0};
    corner_d[2].dz = z0_i - (k2 ? UnitOne : 24'd0) + {SixthOne[22:0], 1'b0};
    corner_d[2].ci = ci_i + 8'(i2);
    corner_d[2].cj = cj_i + 8'(j2);
    corner_d[2].ck = ck_i + 8'(k2);

    // far corner: minus one cell plus half
    corner_d[3].dx = x0_i - (UnitOne >> 1);
    corner_d[3].dy = y0_i - (UnitOne >> 1);
    corner_d[3].dz = z0_i - (UnitOne >> 1);
    corner_d[3].ci = ci_i + 8'd1;
    corner_d[3].cj = cj_i + 8'd1;
    corner_d[3].ck = ck_i + 8'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      corner_q <= corner_d;
    end
  end

  assign corner_o = corner_q;

endmodule
`default_nettype wire

>>> hw/rtl/snx3_corner.sv
`default_nettype none
module snx3_corner import snx3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire corner_t     corner_i,
  output logic signed [63:0] term_o
);

  // stage 1: squares, first hash lookup
  logic [47:0] ex, ey, ez, sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;
  logic [7:0]  a_q, ci1_q, cj1_q;
  ofs_t        dx1_q, dy1_q, dz1_q;
  // stage 2: falloff numerator
  logic [49:0] r2;
  logic [52:0] r5;
  logic        neg_d, neg2_q;
  logic [38:0] diff;
  logic [36:0] m_q;
  logic [7:0]  b_q, ci2_q;
  ofs_t        dx2_q, dy2_q, dz2_q;
  // stage 3: high quotient digit
  logic [24:0] qh_full;
  logic [12:0] qh3_q;
  logic [17:0] mh3_q;
  logic [18:0] ml3_q;
  logic        neg3_q;
  logic [7:0]  c_q;
  ofs_t        dx3_q, dy3_q, dz3_q;
  // stage 4: remainder, gradient index
  logic [17:0] rh_full;
  logic [15:0] c171;
  logic [7:0]  g_full;
  logic [24:0] n_q;
  logic [12:0] qh4_q;
  logic        neg4_q;
  logic [3:0]  g_q;
  ofs_t        dx4_q, dy4_q, dz4_q;
  // stage 5: low quotient digit, gradient dot product
  logic [24:0] ql_full;
  logic signed [25:0] ex5, ey5, ez5, dot_d;
  logic [31:0] t_q;
  logic signed [25:0] dot5_q, dot6_q, dot7_q;
  logic        neg5_q, neg6_q, neg7_q;
  // stages 6 to 8
  logic [63:0] t2p, t4p;
  logic [31:0] t2_q, t4_q;
  logic signed [63:0] t4w, dotw, term_q;

  always_comb begin
    ex = {{24{corner_i.dx[23]}}, corner_i.dx};
    ey = {{24{corner_i.dy[23]}}, corner_i.dy};
    ez = {{24{corner_i.dz[23]}}, corner_i.dz};
    sqx_d = ex * ex;
    sqy_d = ey * ey;
    sqz_d = ez * ez;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      a_q   <= Perm[corner_i.ck];
      ci1_q <= corner_i.ci;
      cj1_q <= corner_i.cj;
      dx1_q <= corner_i.dx;
      dy1_q <= corner_i.dy;
      dz1_q <= corner_i.dz;
    end
  end

  // 0.6 - r^2 scaled: 108*2^32 - 5*r^2, then divided by 4 and by 45
  always_comb begin
    r2    = 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);
    r5    = {r2, 2'b00} + 53'(r2);
    neg_d = (r5 > 53'(FallTop));
    diff  = FallTop - r5[38:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= diff[38:2];
      neg2_q <= neg_d;
      b_q    <= Perm[cj1_q + a_q];
      ci2_q  <= ci1_q;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      dz2_q  <= dz1_q;
    end
  end

  assign qh_full = div45(25'(m_q[36:19]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qh3_q  <= qh_full[12:0];
      mh3_q  <= m_q[36:19];
      ml3_q  <= m_q[18:0];
      neg3_q <= neg2_q;
      c_q    <= Perm[ci2_q + b_q];
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      dz3_q  <= dz2_q;
    end
  end

  // c mod 12 through floor(c*171 / 2048)
  always_comb begin
    rh_full = mh3_q - 18'(qh3_q) * 18'd45;
    c171    = 16'(c_q) * 16'd171;
    g_full  = c_q - 8'(c171[15:11]) * 8'd12;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= {rh_full[5:0], ml3_q};
      qh4_q  <= qh3_q;
      neg4_q <= neg3_q;
      g_q    <= g_full[3:0];
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      dz4_q  <= dz3_q;
    end
  end

  always_comb begin
    ql_full = div45(n_q);
    ex5 = 26'(dx4_q);
    ey5 = 26'(dy4_q);
    ez5 = 26'(dz4_q);
    case (g_q)
      4'd0:    dot_d =  ex5 + ey5;
      4'd1:    dot_d = -ex5 + ey5;
      4'd2:    dot_d =  ex5 - ey5;
      4'd3:    dot_d = -ex5 - ey5;
      4'd4:    dot_d =  ex5 + ez5;
      4'd5:    dot_d = -ex5 + ez5;
      4'd6:    dot_d =  ex5 - ez5;
      4'd7:    dot_d = -ex5 - ez5;
      4'd8:    dot_d =  ey5 + ez5;
      4'd9:    dot_d = -ey5 + ez5;
      4'd10:   dot_d =  ey5 - ez5;
      4'd11:   dot_d = -ey5 - ez5;
      default: dot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= {qh4_q, ql_full[18:0]};
      dot5_q <= dot_d;
      neg5_q <= neg4_q;
    end
  end

  assign t2p = 64'(t_q) * 64'(t_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q   <= t2p[63:32];
      dot6_q <= dot5_q;
      neg6_q <= neg5_q;
    end
  end

  assign t4p = 64'(t2_q) * 64'(t2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_q   <= t4p[63:32];
      dot7_q <= dot6_q;
      neg7_q <= neg6_q;
    end
  end

  always_comb begin
    t4w  = {32'h0, t4_q};
    dotw = {{38{dot7_q[25]}}, dot7_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= neg7_q ? 64'sd0 : t4w * dotw;
    end
  end

  assign term_o = term_q;

endmodule
`default_nettype wire

>>> hw/rtl/simplex_noise_3d.sv
`default_nettype none
// 3d simplex noise, one point per cycle
// a point passes the lattice, simplex and corner stages, then the sum and output registers
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// the 8-stage corner falloff chain (two digit divides by 45, two squarings) sets the depth
// reset: asynchronous active low, clears only the stage valid bits
module simplex_noise_3d import snx3_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [15:0]      noise_value_o
);

  // one enable for every stage; a waiting result freezes the pipe
  logic                 en;
  logic [NumStages-1:0] vld_q, vld_d;

  logic signed [23:0] x0, y0, z0;
  logic [7:0]         ci, cj, ck;
  corner_t [3:0]      corner;
  logic signed [63:0] term [4];

  logic signed [63:0] sum;
  logic signed [33:0] ws;
  logic signed [19:0] w_d, w_q;
  logic [20:0]        p, q;
  logic signed [21:0] v;
  logic signed [15:0] out_d, out_q;

  assign en      = !(vld_q[NumStages-1] && stall_i);
  assign stall_o = !en;
  assign vld_d   = {vld_q[NumStages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // skew, true floor and unskew to the first corner offset
  snx3_lattice u_lattice (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (coord_x_i),
    .y_i   (coord_y_i),
    .z_i   (coord_z_i),
    .x0_o  (x0),
    .y0_o  (y0),
    .z0_o  (z0),
    .ci_o  (ci),
    .cj_o  (cj),
    .ck_o  (ck)
  );

  // rank the offsets and build the four simplex corners
  snx3_simplex u_simplex (
    .clk_i    (clk_i),
    .en_i     (en),
    .x0_i     (x0),
    .y0_i     (y0),
    .z0_i     (z0),
    .ci_i     (ci),
    .cj_i     (cj),
    .ck_i     (ck),
    .corner_o (corner)
  );

  // one falloff and gradient lane per corner
  for (genvar c = 0; c < 4; c++) begin : g_corner
    snx3_corner u_corner (
      .clk_i    (clk_i),
      .en_i     (en),
      .corner_i (corner[c]),
      .term_o   (term[c])
    );
  end

  // sum with rounding bias, scale down by 2^30, clamp far past the output range
  always_comb begin
    sum = term[0] + term[1] + term[2] + term[3] + 64'sd1610612736;
    ws  = sum[63:30];
    if (ws > 34'sd524287) begin
      w_d = 20'sd524287;
    end else if (ws < -34'sd524288) begin
      w_d = -20'sd524288;
    end else begin
      w_d = ws[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= w_d;
    end
  end

  // floor divide by 3 with a positive bias, then saturate to q1.14
  always_comb begin
    p = {w_q[19], w_q} + Div3Bias2;
    q = div3(p);
    v = $signed({1'b0, q}) - 22'sd262144;
    if (v > 22'sd32767) begin
      out_d = 16'sd32767;
    end else if (v < -22'sd32768) begin
      out_d = -16'sd32768;
    end else begin
      out_d = v[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign valid_o       = vld_q[NumStages-1];
  assign noise_value_o = out_q;

endmodule
`default_nettype wire
